// ----- hw/rtl/nps_pkg.sv -----
// Shared constants, types and helpers for the nearest point search block.
package nps_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int NUM_AXES      = 7;
  localparam int AXIS_FIELDS   = 7;
  localparam int AXIS_W        = 8;
  localparam int INDEX_W       = 4;
  localparam int ADDR_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int SQ_W          = 2 * AXIS_W;
  localparam int DIST_W        = 18;

  localparam logic [AXIS_W-1:0] SCORE_MAX = AXIS_W'(160);
  localparam logic [DIST_W-1:0] DIST_MAX  = DIST_W'(179200);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic [NUM_AXES-1:0][AXIS_W-1:0] point_t;

  typedef struct packed {
    logic              live;
    logic              hit;
    logic              last;
    logic [ADDR_W-1:0] idx;
  } scan_tag_t;

  function automatic logic [AXIS_W-1:0] sat_score(input logic [AXIS_W-1:0] raw);
    sat_score = (raw > SCORE_MAX) ? SCORE_MAX : raw;
  endfunction

endpackage

// ----- hw/rtl/nearest_point_search_top.sv -----
// Top level of the nearest point search: request control, scan and best-entry tracking.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid, in_stall, opcode, entry_index,  | request in
//           | axis_drive .. axis_lofi                   |
//   out     | out_valid, out_stall, found, best_index,  | result out
//           | best_distance_sq                          |
//
// A load request writes one memory entry.
// A query reads one table entry per cycle from the single memory read port,
// drains through three pipe stages, then posts unless a held result is stalled.
// rst clears the valid bits and control; table contents stay unknown until loaded.
// in_stall is high while a query runs; a held result does not block loads.
module nearest_point_search_top import nps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic [INDEX_W-1:0] entry_index,
  input  logic [AXIS_W-1:0]  axis_drive,
  input  logic [AXIS_W-1:0]  axis_brightness,
  input  logic [AXIS_W-1:0]  axis_space,
  input  logic [AXIS_W-1:0]  axis_movement,
  input  logic [AXIS_W-1:0]  axis_punch,
  input  logic [AXIS_W-1:0]  axis_width,
  input  logic [AXIS_W-1:0]  axis_lofi,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               found,
  output logic [INDEX_W-1:0] best_index,
  output logic [DIST_W-1:0]  best_distance_sq
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_DONE
  } state_t;

  state_t                        state;
  logic [AXIS_FIELDS-1:0][AXIS_W-1:0] raw_axes;
  point_t                        in_pt;
  point_t                        qry;
  point_t                        rd_data;
  logic                          rd_hit;
  logic                          rd_en;
  logic [ADDR_W-1:0]             cnt;
  logic                          accept;
  logic                          load_ok;
  logic                          wr_en;
  logic [ADDR_W-1:0]             wr_addr;
  scan_tag_t                     tag_rd;
  scan_tag_t                     tag_q;
  scan_tag_t                     tag_d;
  logic [DIST_W-1:0]             distance;
  logic                          best_found;
  logic [ADDR_W-1:0]             best_idx;
  logic [DIST_W-1:0]             best_dist;
  logic                          post;

  assign raw_axes = {axis_lofi, axis_width, axis_punch, axis_movement,
                     axis_space, axis_brightness, axis_drive};

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      in_pt[a] = sat_score(raw_axes[a]);
    end
  end

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign load_ok  = (32'(entry_index) < TABLE_ENTRIES);
  assign wr_en    = accept && (opcode == OP_LOAD) && load_ok;
  assign wr_addr  = ADDR_W'(entry_index);
  assign rd_en    = (state == S_SCAN);
  assign post     = (state == S_DONE) && (!out_valid || !out_stall);

  nps_table u_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_pt),
    .rd_en   (rd_en),
    .rd_addr (cnt),
    .rd_data (rd_data),
    .rd_hit  (rd_hit)
  );

  always_comb begin
    tag_q     = tag_rd;
    tag_q.hit = tag_rd.live && rd_hit;
  end

  nps_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .qry      (qry),
    .ref_pt   (rd_data),
    .tag_in   (tag_q),
    .tag_out  (tag_d),
    .distance (distance)
  );

  always_ff @(posedge clk) begin
    if (accept && (opcode == OP_QUERY)) begin
      qry <= in_pt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      tag_rd     <= '0;
      best_found <= 1'b0;
      best_idx   <= '0;
      best_dist  <= '0;
      out_valid  <= 1'b0;
      found      <= 1'b0;
      best_index <= '0;
      best_distance_sq <= '0;
    end else begin
      tag_rd.live <= rd_en;
      tag_rd.hit  <= 1'b0;
      tag_rd.last <= rd_en && (cnt == ADDR_W'(TABLE_ENTRIES - 1));
      tag_rd.idx  <= cnt;

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (tag_d.live && tag_d.hit && (!best_found || distance < best_dist)) begin
        best_found <= 1'b1;
        best_idx   <= tag_d.idx;
        best_dist  <= distance;
      end

      unique case (state)
        S_IDLE: begin
          if (accept && (opcode == OP_QUERY)) begin
            cnt        <= '0;
            best_found <= 1'b0;
            best_idx   <= '0;
            best_dist  <= '0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          cnt <= cnt + ADDR_W'(1);
          if (cnt == ADDR_W'(TABLE_ENTRIES - 1)) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (tag_d.live && tag_d.last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (post) begin
            out_valid        <= 1'b1;
            found            <= best_found;
            best_index       <= INDEX_W'(best_idx);
            best_distance_sq <= best_dist;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_post_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result posted outside of query completion");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (best_index == '0 && best_distance_sq == '0))
    else $error("not-found result carries nonzero fields");

  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> best_distance_sq <= DIST_MAX)
    else $error("distance beyond table range");

  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && cnt == ADDR_W'(TABLE_ENTRIES - 1)) |=> state == S_WAIT)
    else $error("scan did not stop after last entry");

  a_no_load_in_query: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !wr_en)
    else $error("table write overlaps a scan read");

endmodule

// ----- hw/rtl/nps_table.sv -----
// Point table memory with registered read and per-slot valid bits.
module nps_table import nps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  point_t            wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output point_t            rd_data,
  output logic              rd_hit
);

  point_t                   mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= valid[rd_addr];
      end
    end
  end

endmodule

// ----- hw/rtl/nps_dist.sv -----
// Two-stage squared distance pipe: per-axis squares, then their sum.
module nps_dist import nps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  point_t            qry,
  input  point_t            ref_pt,
  input  scan_tag_t         tag_in,
  output scan_tag_t         tag_out,
  output logic [DIST_W-1:0] distance
);

  logic [NUM_AXES-1:0][SQ_W-1:0] sq;
  logic [NUM_AXES-1:0][SQ_W-1:0] sq_next;
  scan_tag_t                     tag_sq;
  logic [DIST_W-1:0]             distance_next;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      logic [AXIS_W-1:0] diff;
      diff = (qry[a] >= ref_pt[a]) ? (qry[a] - ref_pt[a]) : (ref_pt[a] - qry[a]);
      sq_next[a] = SQ_W'(diff) * SQ_W'(diff);
    end
  end

  always_comb begin
    distance_next = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      distance_next = distance_next + DIST_W'(sq[a]);
    end
  end

  always_ff @(posedge clk) begin
    sq       <= sq_next;
    distance <= distance_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_sq  <= '0;
      tag_out <= '0;
    end else begin
      tag_sq  <= tag_in;
      tag_out <= tag_sq;
    end
  end

endmodule
